[sv/hsv2rgb_pkg.sv]
// Package: pixel types, conversion constants and sector codes for the HSV to RGB core.
package hsv2rgb_pkg;

    localparam int unsigned HueWidth   = 9;
    localparam int unsigned SatWidth   = 9;
    localparam int unsigned ChanWidth  = 8;

    localparam int unsigned HueWrap    = 360;
    localparam int unsigned SectorDeg  = 60;
    localparam int unsigned SatOne     = 256;
    localparam int unsigned QtOne      = 15360;

    // floor(x / 15) == (x * 2185) >> 15 for every x below 4681
    localparam int unsigned RecipQt    = 2185;
    localparam int unsigned RecipShift = 15;
    localparam int unsigned QtPreShift = 10;

    typedef enum logic [2:0] {
        SEC_0 = 3'd0,
        SEC_1 = 3'd1,
        SEC_2 = 3'd2,
        SEC_3 = 3'd3,
        SEC_4 = 3'd4,
        SEC_5 = 3'd5
    } t_sector;

    typedef struct packed {
        logic [HueWidth-1:0]  hue_degrees;
        logic [SatWidth-1:0]  saturation;
        logic [ChanWidth-1:0] brightness;
    } t_hsv_word;

    typedef struct packed {
        logic [ChanWidth-1:0] red;
        logic [ChanWidth-1:0] green;
        logic [ChanWidth-1:0] blue;
    } t_rgb_word;

endpackage

[sv/hsv2rgb_if.sv]
// Interfaces: valid/ready streams for HSV input words and RGB output words.
interface hsv2rgb_hsv_if;
    import hsv2rgb_pkg::*;

    logic      valid;
    logic      ready;
    t_hsv_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface hsv2rgb_rgb_if;
    import hsv2rgb_pkg::*;

    logic      valid;
    logic      ready;
    t_rgb_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/hsv_to_rgb_converter_core.sv]
// Top level: four-stage pipelined HSV to RGB pixel converter.
//
// Usage:
//   i_pix carries one HSV word (hue in degrees, saturation with 256 = 1.0,
//   brightness) per valid/ready handshake; o_pix returns one RGB word for
//   each accepted input word, in order.
//   Pipeline: stage 1 wraps the hue and finds sector and remainder,
//   stage 2 forms the three level factors, stage 3 multiplies them by the
//   brightness, stage 4 scales, clamps and routes the channels into the
//   output register.
//   Throughput: one word per cycle while o_pix.ready is high; the brightness
//   multiply is done in stage 3 and the reciprocal multiply in stage 4.
//   Each stage has its own ready, so bubbles are squeezed out and new words
//   are taken while a finished word waits at the output.
//   Reset (i_rst_n low, synchronous) empties the pipeline; no word is lost
//   or repeated when o_pix.ready is held low, the stages simply hold.
module hsv_to_rgb_converter_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    hsv2rgb_hsv_if.sink          i_pix,
    hsv2rgb_rgb_if.source        o_pix
);
    import hsv2rgb_pkg::*;

    localparam int unsigned RemWidth  = 6;
    localparam int unsigned DpWidth   = 10;
    localparam int unsigned DqWidth   = 16;
    localparam int unsigned NpWidth   = DpWidth + ChanWidth + 1;
    localparam int unsigned NqWidth   = DqWidth + ChanWidth + 1;
    localparam int unsigned QxWidth   = 12;
    localparam int unsigned QyWidth   = 2 * QxWidth;

    // stage handshake
    logic s1_ready, s2_ready, s3_ready, s4_ready;

    // stage 1
    logic                  r_s1_valid;
    t_sector               r_s1_sector, n_s1_sector;
    logic [RemWidth-1:0]   r_s1_rem,    n_s1_rem;
    logic [SatWidth-1:0]   r_s1_sat;
    logic [ChanWidth-1:0]  r_s1_val;
    logic                  r_s1_grey;
    logic [HueWidth-1:0]   hue_wrap;
    logic [HueWidth-1:0]   sector_base;

    // stage 2
    logic                        r_s2_valid;
    t_sector                     r_s2_sector;
    logic [ChanWidth-1:0]        r_s2_val;
    logic                        r_s2_grey;
    logic signed [DpWidth-1:0]   r_s2_dp, n_s2_dp;
    logic signed [DqWidth-1:0]   r_s2_dq, n_s2_dq;
    logic signed [DqWidth-1:0]   r_s2_dt, n_s2_dt;
    logic [DqWidth-2:0]          kq, kt;

    // stage 3
    logic                        r_s3_valid;
    t_sector                     r_s3_sector;
    logic [ChanWidth-1:0]        r_s3_val;
    logic                        r_s3_grey;
    logic signed [NpWidth-1:0]   r_s3_np, n_s3_np;
    logic signed [NqWidth-1:0]   r_s3_nq, n_s3_nq;
    logic signed [NqWidth-1:0]   r_s3_nt, n_s3_nt;
    logic signed [ChanWidth:0]   val_sx;

    // stage 4
    logic                  r_s4_valid;
    t_rgb_word             r_s4_pix, n_s4_pix;
    logic [ChanWidth-1:0]  lvl_p, lvl_q, lvl_t;
    logic [QxWidth-1:0]    qx, tx;
    logic [QyWidth-1:0]    qy, ty;

    assign s4_ready    = !r_s4_valid || o_pix.ready;
    assign s3_ready    = !r_s3_valid || s4_ready;
    assign s2_ready    = !r_s2_valid || s3_ready;
    assign s1_ready    = !r_s1_valid || s2_ready;
    assign i_pix.ready = s1_ready;

    assign o_pix.valid = r_s4_valid;
    assign o_pix.data  = r_s4_pix;

    // ---------------- stage 1: hue wrap, sector, remainder
    always_comb begin
        hue_wrap = (i_pix.data.hue_degrees >= HueWidth'(HueWrap)) ?
                   '0 : i_pix.data.hue_degrees;
        priority if (hue_wrap >= HueWidth'(5 * SectorDeg)) begin
            n_s1_sector = SEC_5;
            sector_base = HueWidth'(5 * SectorDeg);
        end else if (hue_wrap >= HueWidth'(4 * SectorDeg)) begin
            n_s1_sector = SEC_4;
            sector_base = HueWidth'(4 * SectorDeg);
        end else if (hue_wrap >= HueWidth'(3 * SectorDeg)) begin
            n_s1_sector = SEC_3;
            sector_base = HueWidth'(3 * SectorDeg);
        end else if (hue_wrap >= HueWidth'(2 * SectorDeg)) begin
            n_s1_sector = SEC_2;
            sector_base = HueWidth'(2 * SectorDeg);
        end else if (hue_wrap >= HueWidth'(SectorDeg)) begin
            n_s1_sector = SEC_1;
            sector_base = HueWidth'(SectorDeg);
        end else begin
            n_s1_sector = SEC_0;
            sector_base = '0;
        end
        n_s1_rem = RemWidth'(hue_wrap - sector_base);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_pix.valid) begin
            r_s1_sector <= n_s1_sector;
            r_s1_rem    <= n_s1_rem;
            r_s1_sat    <= i_pix.data.saturation;
            r_s1_val    <= i_pix.data.brightness;
            r_s1_grey   <= (i_pix.data.saturation == '0);
        end
    end

    // ---------------- stage 2: level factors (one - k)
    always_comb begin
        kq = (DqWidth-1)'(r_s1_sat) * (DqWidth-1)'(r_s1_rem);
        kt = (DqWidth-1)'(r_s1_sat) * (DqWidth-1)'(RemWidth'(SectorDeg) - r_s1_rem);
        n_s2_dp = DpWidth'(SatOne) - $signed({1'b0, r_s1_sat});
        n_s2_dq = DqWidth'(QtOne) - $signed({1'b0, kq});
        n_s2_dt = DqWidth'(QtOne) - $signed({1'b0, kt});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_ready) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready && r_s1_valid) begin
            r_s2_sector <= r_s1_sector;
            r_s2_val    <= r_s1_val;
            r_s2_grey   <= r_s1_grey;
            r_s2_dp     <= n_s2_dp;
            r_s2_dq     <= n_s2_dq;
            r_s2_dt     <= n_s2_dt;
        end
    end

    // ---------------- stage 3: numerators v * (one - k)
    always_comb begin
        val_sx  = $signed({1'b0, r_s2_val});
        n_s3_np = NpWidth'(val_sx) * NpWidth'(r_s2_dp);
        n_s3_nq = NqWidth'(val_sx) * NqWidth'(r_s2_dq);
        n_s3_nt = NqWidth'(val_sx) * NqWidth'(r_s2_dt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (s3_ready) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_ready && r_s2_valid) begin
            r_s3_sector <= r_s2_sector;
            r_s3_val    <= r_s2_val;
            r_s3_grey   <= r_s2_grey;
            r_s3_np     <= n_s3_np;
            r_s3_nq     <= n_s3_nq;
            r_s3_nt     <= n_s3_nt;
        end
    end

    // ---------------- stage 4: scale, clamp, sector routing
    always_comb begin
        // num / 15360 = (num >> 10) / 15, the latter by reciprocal
        qx = r_s3_nq[QtPreShift +: QxWidth];
        tx = r_s3_nt[QtPreShift +: QxWidth];
        qy = QyWidth'(qx) * QyWidth'(RecipQt);
        ty = QyWidth'(tx) * QyWidth'(RecipQt);

        lvl_p = (r_s3_np <= 0) ? '0 : r_s3_np[ChanWidth +: ChanWidth];
        lvl_q = (r_s3_nq <= 0) ? '0 : qy[RecipShift +: ChanWidth];
        lvl_t = (r_s3_nt <= 0) ? '0 : ty[RecipShift +: ChanWidth];

        if (r_s3_grey) begin
            n_s4_pix = '{red: r_s3_val, green: r_s3_val, blue: r_s3_val};
        end else begin
            unique case (r_s3_sector)
                SEC_0:   n_s4_pix = '{red: r_s3_val, green: lvl_t,    blue: lvl_p};
                SEC_1:   n_s4_pix = '{red: lvl_q,    green: r_s3_val, blue: lvl_p};
                SEC_2:   n_s4_pix = '{red: lvl_p,    green: r_s3_val, blue: lvl_t};
                SEC_3:   n_s4_pix = '{red: lvl_p,    green: lvl_q,    blue: r_s3_val};
                SEC_4:   n_s4_pix = '{red: lvl_t,    green: lvl_p,    blue: r_s3_val};
                SEC_5:   n_s4_pix = '{red: r_s3_val, green: lvl_p,    blue: lvl_q};
                default: n_s4_pix = '{red: r_s3_val, green: lvl_p,    blue: lvl_q};
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else if (s4_ready) begin
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s4_ready && r_s3_valid) begin
            r_s4_pix <= n_s4_pix;
        end
    end

    // ---------------- checks
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> (r_s1_rem < RemWidth'(SectorDeg)))
        else $error("sector remainder out of range");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s2_ready) |=> (r_s1_valid && $stable(r_s1_rem)))
        else $error("stage 1 word dropped under stall");

    a_s3_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_valid && !s4_ready) |=> (r_s3_valid && $stable(r_s3_nq)))
        else $error("stage 3 word dropped under stall");

    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_valid && !r_s3_grey) |-> (lvl_q <= r_s3_val && lvl_p <= r_s3_val))
        else $error("derived level exceeds brightness");

endmodule

[bench/hsv_to_rgb_converter_checker.sv]
// Checker: predicts the RGB word for every accepted HSV word and compares it with the core's output.
`timescale 1ns / 100ps

module hsv_to_rgb_converter_checker
    import hsv2rgb_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    hsv2rgb_hsv_if i_hsv,
    hsv2rgb_rgb_if i_rgb,
    output int     o_error_count,
    output int     o_pending,
    output int     o_checked
);

    localparam int MaxPrinted = 40;

    t_rgb_word expected_rgb_q[$];

    initial begin
        o_error_count = 0;
        o_pending     = 0;
        o_checked     = 0;
    end

    task automatic report_mismatch(input string msg);
        if (o_error_count < MaxPrinted) begin
            $display("MISMATCH at %0t ns: %s", $time, msg);
        end
        o_error_count++;
    endtask

    // floor(v * (one - k) / one); a numerator at or below zero clamps to 0
    function automatic logic [ChanWidth-1:0] scaled_level(input longint v, input longint k,
                                                          input longint one);
        longint num;
        num = v * (one - k);
        if (num <= 0) begin
            return '0;
        end
        return ChanWidth'(num / one);
    endfunction

    function automatic t_rgb_word convert_hsv(input t_hsv_word w);
        longint               h;
        longint               s;
        longint               v;
        longint               r;
        logic [ChanWidth-1:0] vb;
        logic [ChanWidth-1:0] p;
        logic [ChanWidth-1:0] q;
        logic [ChanWidth-1:0] t;
        t_sector              sec;
        t_rgb_word            rgb;
        h  = longint'(w.hue_degrees);
        s  = longint'(w.saturation);
        v  = longint'(w.brightness);
        vb = w.brightness;
        rgb.red   = vb;
        rgb.green = vb;
        rgb.blue  = vb;
        // grey: no hue dependence at all
        if (s == 0) begin
            return rgb;
        end
        if (h >= HueWrap) begin
            h = 0;
        end
        sec = t_sector'(h / SectorDeg);
        r   = h % SectorDeg;
        p   = scaled_level(v, s, SatOne);
        q   = scaled_level(v, s * r, QtOne);
        t   = scaled_level(v, s * (SectorDeg - r), QtOne);
        case (sec)
            SEC_0: begin
                rgb.red = vb; rgb.green = t;  rgb.blue = p;
            end
            SEC_1: begin
                rgb.red = q;  rgb.green = vb; rgb.blue = p;
            end
            SEC_2: begin
                rgb.red = p;  rgb.green = vb; rgb.blue = t;
            end
            SEC_3: begin
                rgb.red = p;  rgb.green = q;  rgb.blue = vb;
            end
            SEC_4: begin
                rgb.red = t;  rgb.green = p;  rgb.blue = vb;
            end
            default: begin
                rgb.red = vb; rgb.green = p;  rgb.blue = q;
            end
        endcase
        return rgb;
    endfunction

    always @(posedge i_clk) begin
        t_rgb_word want;
        t_rgb_word got;
        if (!i_rst_n) begin
            expected_rgb_q.delete();
        end else begin
            if (i_hsv.valid && i_hsv.ready) begin
                expected_rgb_q.push_back(convert_hsv(i_hsv.data));
            end
            if (i_rgb.valid && i_rgb.ready) begin
                got = i_rgb.data;
                if (expected_rgb_q.size() == 0) begin
                    report_mismatch($sformatf("RGB word %h with no word expected", got));
                end else begin
                    want = expected_rgb_q.pop_front();
                    if (got.red !== want.red) begin
                        report_mismatch($sformatf("word %0d red %0d, expected %0d",
                                                  o_checked, got.red, want.red));
                    end
                    if (got.green !== want.green) begin
                        report_mismatch($sformatf("word %0d green %0d, expected %0d",
                                                  o_checked, got.green, want.green));
                    end
                    if (got.blue !== want.blue) begin
                        report_mismatch($sformatf("word %0d blue %0d, expected %0d",
                                                  o_checked, got.blue, want.blue));
                    end
                    o_checked++;
                end
            end
        end
        o_pending = expected_rgb_q.size();
    end

endmodule

[bench/hsv_to_rgb_converter_core_test.sv]
// Testbench top: drives HSV words into the converter core, stalls the RGB side and gives the verdict.
`timescale 1ns / 100ps

module hsv_to_rgb_converter_core_test;
    import hsv2rgb_pkg::*;

    localparam int RandomWords = 1025;
    localparam int CycleLimit  = 200000;
    localparam int DrainCycles = 16;
    localparam int MaxWait     = 8;

    logic clk;
    logic rst_n;
    int   cycle_count = 0;
    int   words_sent = 0;
    int   directed_words = 0;
    int   error_count;
    int   pending_words;
    int   checked_words;
    int unsigned hsv_steady = 0;
    int unsigned rgb_steady = 0;

    hsv2rgb_hsv_if hsv_bus();
    hsv2rgb_rgb_if rgb_bus();

    hsv_to_rgb_converter_core i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_pix   (hsv_bus),
        .o_pix   (rgb_bus)
    );

    hsv_to_rgb_converter_checker rgb_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_hsv         (hsv_bus),
        .i_rgb         (rgb_bus),
        .o_error_count (error_count),
        .o_pending     (pending_words),
        .o_checked     (checked_words)
    );

    always begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // gap before the next word; now and then a run of back-to-back words
    function automatic int unsigned draw_wait(inout int unsigned steady);
        if (steady > 0) begin
            steady--;
            return 0;
        end
        if ($urandom_range(0, 7) == 0) begin
            steady = $urandom_range(16, 64);
            return 0;
        end
        return $urandom_range(0, MaxWait);
    endfunction

    task automatic send_hsv(input logic [HueWidth-1:0] h, input logic [SatWidth-1:0] s,
                            input logic [ChanWidth-1:0] v);
        int unsigned gap;
        t_hsv_word   w;
        gap = draw_wait(hsv_steady);
        if (gap > 0) begin
            hsv_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        w.hue_degrees = h;
        w.saturation  = s;
        w.brightness  = v;
        hsv_bus.valid <= 1'b1;
        hsv_bus.data  <= w;
        do @(posedge clk); while (!hsv_bus.ready);
        words_sent++;
    endtask

    initial begin
        rst_n         = 1'b0;
        hsv_bus.valid = 1'b0;
        hsv_bus.data  = '0;
        rgb_bus.ready = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    // RGB side: random stalls between words
    initial begin
        int unsigned stall;
        @(posedge clk iff rst_n);
        forever begin
            stall = draw_wait(rgb_steady);
            if (stall > 0) begin
                rgb_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rgb_bus.ready <= 1'b1;
            do @(posedge clk); while (!rgb_bus.valid);
        end
    end

    initial begin
        int unsigned kind;
        @(posedge clk iff rst_n);

        // sector edges at full saturation and brightness
        send_hsv(9'd0,   9'd256, 8'd255);
        send_hsv(9'd59,  9'd256, 8'd255);
        send_hsv(9'd60,  9'd256, 8'd255);
        send_hsv(9'd119, 9'd256, 8'd255);
        send_hsv(9'd120, 9'd256, 8'd255);
        send_hsv(9'd179, 9'd256, 8'd255);
        send_hsv(9'd180, 9'd256, 8'd255);
        send_hsv(9'd239, 9'd256, 8'd255);
        send_hsv(9'd240, 9'd256, 8'd255);
        send_hsv(9'd299, 9'd256, 8'd255);
        send_hsv(9'd300, 9'd256, 8'd255);
        send_hsv(9'd359, 9'd256, 8'd255);
        // hue wrap, grey, and saturation beyond 1.0
        send_hsv(9'd360, 9'd256, 8'd200);
        send_hsv(9'd511, 9'd300, 8'd255);
        send_hsv(9'd400, 9'd0,   8'd77);
        send_hsv(9'd100, 9'd0,   8'd255);
        send_hsv(9'd30,  9'd1,   8'd255);
        send_hsv(9'd30,  9'd511, 8'd255);
        send_hsv(9'd200, 9'd257, 8'd128);
        send_hsv(9'd0,   9'd0,   8'd0);
        send_hsv(9'd45,  9'd128, 8'd0);
        send_hsv(9'd330, 9'd255, 8'd255);
        send_hsv(9'd50,  9'd400, 8'd255);
        send_hsv(9'd10,  9'd300, 8'd255);
        directed_words = words_sent;

        repeat (RandomWords) begin
            kind = $urandom_range(0, 9);
            if (kind <= 6) begin
                send_hsv(HueWidth'($urandom_range(0, HueWrap - 1)),
                         SatWidth'($urandom_range(1, SatOne)), ChanWidth'($urandom));
            end else if (kind == 7) begin
                send_hsv(HueWidth'($urandom), '0, ChanWidth'($urandom));
            end else if (kind == 8) begin
                send_hsv(HueWidth'($urandom_range(HueWrap, 511)), SatWidth'($urandom),
                         ChanWidth'($urandom));
            end else begin
                send_hsv(HueWidth'($urandom), SatWidth'($urandom_range(SatOne + 1, 511)),
                         ChanWidth'($urandom));
            end
        end
        hsv_bus.valid <= 1'b0;

        // let the last accepted word be counted before draining
        @(posedge clk);
        while (pending_words != 0) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        $display("Sent %0d HSV words (%0d directed), compared %0d RGB words",
                 words_sent, directed_words, checked_words);
        $display("All six sectors, grey, wrapped hues and saturation above 1.0 under stalls");
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[hsv_to_rgb_converter_core.f]
sv/hsv2rgb_pkg.sv
sv/hsv2rgb_if.sv
sv/hsv_to_rgb_converter_core.sv
bench/hsv_to_rgb_converter_checker.sv
bench/hsv_to_rgb_converter_core_test.sv
